FILE: design/name_directory_table_assert.svh
// Assertion macros for the name directory table.
// Each macro checks an implication on the rising clock edge, disabled in reset.
`ifndef NAME_DIRECTORY_TABLE_ASSERT_SVH
`define NAME_DIRECTORY_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define NDT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("name directory table check failed");

// Consequent must hold in the cycle after the antecedent.
`define NDT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("name directory table check failed");

`else

`define NDT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NDT_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: design/ndt_pkg.sv
`timescale 1ns / 1ps

package ndt_pkg;

   localparam int DEF_TABLE_ENTRIES = 64;
   localparam int DEF_NAME_BYTES    = 8;
   localparam int KEY_W             = 64;
   localparam int SECTOR_W          = 16;
   localparam int SLOT_W            = 6;
   localparam int FUNC_W            = 3;
   localparam int STATUS_W          = 3;

   typedef enum logic [FUNC_W-1:0] {
      FN_FIND          = 3'd0,
      FN_ADD           = 3'd1,
      FN_REMOVE        = 3'd2,
      FN_MARK          = 3'd3,
      FN_QUERY         = 3'd4,
      FN_REMOVE_MARKED = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NOT_FOUND  = 3'd1,
      ST_DUPLICATE  = 3'd2,
      ST_FULL       = 3'd3,
      ST_NOT_MARKED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // Per-entry verdict for the entry being examined.
   typedef struct packed {
      logic hit;
      logic free;
   } match_type;

endpackage

FILE: design/name_directory_table.sv
`timescale 1ns / 1ps
`include "name_directory_table_assert.svh"
//
// Channel   Ports                                       Handshake
// request   req_func, req_name_key, req_sector_in       start high while busy is low
// response  rsp_status, rsp_sector_out, rsp_slot_index,  rsp_valid high for one cycle
//           rsp_is_marked
//
// A request scans the entry memory from slot zero, one entry per cycle, through the single
// read port, whose read data is registered. A hit at slot k stops the scan and the finish
// state registers the result; a scan that finds nothing, and every add without a duplicate,
// runs through all TABLE_ENTRIES slots. Busy stays high until a request has finished, so a
// new request is taken only after the last one. After reset a clearing pass writes every
// entry empty, and busy stays high meanwhile. The receiver cannot stall: the response
// fields stay on the ports until the next response, but rsp_valid marks them only for its
// strobe cycle, and a new request may be accepted in that same cycle.
//
module name_directory_table #(
   parameter int TABLE_ENTRIES = ndt_pkg::DEF_TABLE_ENTRIES,
   parameter int NAME_BYTES    = ndt_pkg::DEF_NAME_BYTES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ndt_pkg::FUNC_W-1:0]   req_func,
   input  logic [ndt_pkg::KEY_W-1:0]    req_name_key,
   input  logic [ndt_pkg::SECTOR_W-1:0] req_sector_in,
   output logic                         rsp_valid,
   output logic [ndt_pkg::STATUS_W-1:0] rsp_status,
   output logic [ndt_pkg::SECTOR_W-1:0] rsp_sector_out,
   output logic [ndt_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic                         rsp_is_marked
);

   import ndt_pkg::*;

   localparam int ADDR_W    = $clog2(TABLE_ENTRIES);
   localparam int NAME_BITS = NAME_BYTES * 8;
   localparam int ENTRY_W   = NAME_BITS + SECTOR_W + 2;

   logic [NAME_BITS-1:0] canon_key;
   logic [ADDR_W-1:0]    mem_rd_addr;
   logic [ENTRY_W-1:0]   mem_rd_data;
   logic                 mem_wr_en;
   logic [ADDR_W-1:0]    mem_wr_addr;
   logic [ENTRY_W-1:0]   mem_wr_data;
   logic [NAME_BITS-1:0] cmp_key;
   logic [SECTOR_W-1:0]  cmp_sector;
   logic [FUNC_W-1:0]    cmp_func;
   match_type            verdict;
   status_type           status;

   // Names are kept in canonical form: only the first NAME_BYTES bytes count, and the first
   // zero byte ends the name, so every byte after it reads as zero.
   always_comb begin
      logic alive;
      alive     = 1'b1;
      canon_key = '0;
      for (int b = 0; b < NAME_BYTES; b++) begin
         if (alive && req_name_key[KEY_W-1-8*b -: 8] != 8'd0) begin
            canon_key[NAME_BITS-1-8*b -: 8] = req_name_key[KEY_W-1-8*b -: 8];
         end else begin
            alive = 1'b0;
         end
      end
   end

   ndt_mem #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // The entry read back from memory is judged against the stored request.
   ndt_match #(
      .NAME_BITS (NAME_BITS)
   ) u_match (
      .func    (cmp_func),
      .key     (cmp_key),
      .sector  (cmp_sector),
      .entry   (mem_rd_data),
      .verdict (verdict)
   );

   ndt_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NAME_BITS     (NAME_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .func           (req_func),
      .key            (canon_key),
      .sector         (req_sector_in),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .cmp_key        (cmp_key),
      .cmp_sector     (cmp_sector),
      .cmp_func       (cmp_func),
      .verdict        (verdict),
      .rsp_valid      (rsp_valid),
      .rsp_status     (status),
      .rsp_sector_out (rsp_sector_out),
      .rsp_slot_index (rsp_slot_index),
      .rsp_is_marked  (rsp_is_marked)
   );

   assign rsp_status = status;

   // An accepted request always starts a scan, so the block is busy in the next cycle.
   `NDT_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A response strobe lasts one cycle, since another scan must run before the next one.
   `NDT_ASSERT_NXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   // The response is shown while the block is ready for the next request.
   `NDT_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_valid, !busy)
   // A missing key reports nothing but its status.
   `NDT_ASSERT_IMP(a_not_found_zero, clock, reset,
      rsp_valid && rsp_status == ST_NOT_FOUND,
      rsp_sector_out == '0 && rsp_slot_index == '0 && !rsp_is_marked)

endmodule

FILE: design/ndt_mem.sv
`timescale 1ns / 1ps

module ndt_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 82
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/ndt_match.sv
`timescale 1ns / 1ps

module ndt_match #(
   parameter int NAME_BITS = 64
) (
   input  logic [ndt_pkg::FUNC_W-1:0]          func,
   input  logic [NAME_BITS-1:0]                key,
   input  logic [ndt_pkg::SECTOR_W-1:0]        sector,
   input  logic [NAME_BITS+ndt_pkg::SECTOR_W+1:0] entry,
   output ndt_pkg::match_type                  verdict
);

   import ndt_pkg::*;

   localparam int ENTRY_W  = NAME_BITS + SECTOR_W + 2;
   localparam int USED_BIT = ENTRY_W - 1;
   localparam int MARK_BIT = ENTRY_W - 2;

   logic used;
   logic marked;
   logic name_eq;
   logic sector_eq;

   assign used      = entry[USED_BIT];
   assign marked    = entry[MARK_BIT];
   assign name_eq   = entry[SECTOR_W +: NAME_BITS] == key;
   assign sector_eq = entry[SECTOR_W-1:0] == sector;

   always_comb begin
      verdict.free = !used;
      case (func)
         FN_FIND, FN_ADD, FN_REMOVE: verdict.hit = used && !marked && name_eq;
         FN_MARK:                    verdict.hit = used && !marked && sector_eq;
         FN_QUERY, FN_REMOVE_MARKED: verdict.hit = used && sector_eq;
         default:                    verdict.hit = 1'b0;
      endcase
   end

endmodule

FILE: design/ndt_ctrl.sv
`timescale 1ns / 1ps

module ndt_ctrl #(
   parameter int TABLE_ENTRIES = 64,
   parameter int NAME_BITS     = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ndt_pkg::FUNC_W-1:0]            func,
   input  logic [NAME_BITS-1:0]                  key,
   input  logic [ndt_pkg::SECTOR_W-1:0]          sector,
   output logic [$clog2(TABLE_ENTRIES)-1:0]      mem_rd_addr,
   input  logic [NAME_BITS+ndt_pkg::SECTOR_W+1:0] mem_rd_data,
   output logic                                  mem_wr_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0]      mem_wr_addr,
   output logic [NAME_BITS+ndt_pkg::SECTOR_W+1:0] mem_wr_data,
   output logic [NAME_BITS-1:0]                  cmp_key,
   output logic [ndt_pkg::SECTOR_W-1:0]          cmp_sector,
   output logic [ndt_pkg::FUNC_W-1:0]            cmp_func,
   input  ndt_pkg::match_type                    verdict,
   output logic                                  rsp_valid,
   output ndt_pkg::status_type                   rsp_status,
   output logic [ndt_pkg::SECTOR_W-1:0]          rsp_sector_out,
   output logic [ndt_pkg::SLOT_W-1:0]            rsp_slot_index,
   output logic                                  rsp_is_marked
);

   import ndt_pkg::*;

   localparam int ADDR_W   = $clog2(TABLE_ENTRIES);
   localparam int ENTRY_W  = NAME_BITS + SECTOR_W + 2;
   localparam int USED_BIT = ENTRY_W - 1;
   localparam int MARK_BIT = ENTRY_W - 2;
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_ENTRIES - 1);

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    addr_ff;
   logic [ADDR_W-1:0]    rd_addr_ff;
   logic [FUNC_W-1:0]    func_ff;
   logic [NAME_BITS-1:0] key_ff;
   logic [SECTOR_W-1:0]  sec_ff;
   logic                 found_ff;
   logic [ADDR_W-1:0]    hit_addr_ff;
   logic [ENTRY_W-1:0]   hit_word_ff;
   logic                 free_found_ff;
   logic [ADDR_W-1:0]    free_addr_ff;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff, rsp_status_in;
   logic [SECTOR_W-1:0]  rsp_sector_ff, rsp_sector_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_marked_ff, rsp_marked_in;

   logic                 accept;
   logic [ADDR_W-1:0]    rep_addr;
   logic [ADDR_W+SLOT_W-1:0] rep_addr_wide;

   assign accept = (state_ff == S_IDLE) && start;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (addr_ff == LAST) state_in = S_IDLE;
         S_IDLE:   if (start) state_in = S_SCAN;
         S_SCAN:   if (verdict.hit || rd_addr_ff == LAST) state_in = S_FINISH;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   // Outputs: memory access and the result of a finished scan.
   always_comb begin
      busy          = state_ff != S_IDLE;
      mem_rd_addr   = (state_ff == S_SCAN) ? addr_ff : '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_ff;
      mem_wr_data   = '0;
      rsp_status_in = ST_NOT_FOUND;
      rsp_sector_in = '0;
      rsp_marked_in = 1'b0;
      rep_addr      = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         S_FINISH: begin
            if (found_ff) begin
               rep_addr      = hit_addr_ff;
               rsp_sector_in = hit_word_ff[SECTOR_W-1:0];
               mem_wr_addr   = hit_addr_ff;
               mem_wr_data   = hit_word_ff;
            end
            case (func_ff)
               FN_FIND: begin
                  if (found_ff) rsp_status_in = ST_OK;
               end
               FN_ADD: begin
                  if (found_ff) begin
                     rsp_status_in = ST_DUPLICATE;
                  end else if (free_found_ff) begin
                     rsp_status_in = ST_OK;
                     rsp_sector_in = sec_ff;
                     rep_addr      = free_addr_ff;
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = free_addr_ff;
                     mem_wr_data   = {1'b1, 1'b0, key_ff, sec_ff};
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end
               FN_REMOVE: begin
                  if (found_ff) begin
                     rsp_status_in         = ST_OK;
                     mem_wr_en             = 1'b1;
                     mem_wr_data[USED_BIT] = 1'b0;
                  end
               end
               FN_MARK: begin
                  if (found_ff) begin
                     rsp_status_in         = ST_OK;
                     mem_wr_en             = 1'b1;
                     mem_wr_data[MARK_BIT] = 1'b1;
                  end
               end
               FN_QUERY: begin
                  if (found_ff) begin
                     rsp_status_in = ST_OK;
                     rsp_marked_in = hit_word_ff[MARK_BIT];
                  end
               end
               FN_REMOVE_MARKED: begin
                  if (found_ff) begin
                     if (hit_word_ff[MARK_BIT]) begin
                        rsp_status_in         = ST_OK;
                        mem_wr_en             = 1'b1;
                        mem_wr_data[USED_BIT] = 1'b0;
                     end else begin
                        rsp_status_in = ST_NOT_MARKED;
                     end
                  end
               end
               default: begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            endcase
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
      rep_addr_wide = {{SLOT_W{1'b0}}, rep_addr};
      rsp_slot_in   = rep_addr_wide[SLOT_W-1:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         addr_ff       <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= state_ff == S_FINISH;
         case (state_ff)
            S_CLEAR: begin
               addr_ff <= (addr_ff == LAST) ? '0 : addr_ff + 1'b1;
            end
            S_IDLE: begin
               // Entry zero is read every idle cycle, so the scan starts at one.
               addr_ff <= ADDR_W'(1);
               if (accept) begin
                  found_ff      <= 1'b0;
                  free_found_ff <= 1'b0;
               end
            end
            S_SCAN: begin
               if (addr_ff != LAST) addr_ff <= addr_ff + 1'b1;
               if (verdict.hit) found_ff <= 1'b1;
               if (verdict.free && !free_found_ff) free_found_ff <= 1'b1;
            end
            default: begin
               addr_ff <= addr_ff;
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_addr_ff <= mem_rd_addr;
      if (accept) begin
         func_ff <= func;
         key_ff  <= key;
         sec_ff  <= sector;
      end
      if (state_ff == S_SCAN) begin
         if (verdict.hit) begin
            hit_addr_ff <= rd_addr_ff;
            hit_word_ff <= mem_rd_data;
         end
         if (verdict.free && !free_found_ff) free_addr_ff <= rd_addr_ff;
      end
      if (state_ff == S_FINISH) begin
         rsp_status_ff <= rsp_status_in;
         rsp_sector_ff <= rsp_sector_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_marked_ff <= rsp_marked_in;
      end
   end

   assign cmp_key        = key_ff;
   assign cmp_sector     = sec_ff;
   assign cmp_func       = func_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_sector_out = rsp_sector_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_is_marked  = rsp_marked_ff;

endmodule

FILE: sim/ndt_reply_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the name directory table, keeps its own copy of the
// directory and compares every response against the oldest predicted one.
module ndt_reply_checker
   import ndt_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int NAME_BYTES    = DEF_NAME_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [KEY_W-1:0]    req_name_key,
   input  logic [SECTOR_W-1:0] req_sector_in,
   input  logic                rsp_valid,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [SECTOR_W-1:0] rsp_sector_out,
   input  logic [SLOT_W-1:0]   rsp_slot_index,
   input  logic                rsp_is_marked,
   output int                  error_count,
   output int                  pending_count,
   output int                  replies_checked,
   output int                  full_replies
);

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [STATUS_W-1:0] status;
      logic [SECTOR_W-1:0] sector;
      logic [SLOT_W-1:0]   slot;
      logic                marked;
   } dir_reply_type;

   logic                slot_used   [TABLE_ENTRIES];
   logic                slot_marked [TABLE_ENTRIES];
   logic [KEY_W-1:0]    slot_name   [TABLE_ENTRIES];
   logic [SECTOR_W-1:0] slot_sector [TABLE_ENTRIES];

   dir_reply_type replies_due[$];
   int mismatches    = 0;
   int checked_total = 0;
   int full_total    = 0;

   // Bytes past the first zero byte, or past NAME_BYTES, do not belong to the name.
   function automatic logic [KEY_W-1:0] canonical_name(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] kept;
      logic ended;
      kept  = '0;
      ended = 1'b0;
      for (int b = 0; b < NAME_BYTES && b < 8; b++) begin
         if (key[KEY_W-1-8*b -: 8] == 8'h00) ended = 1'b1;
         if (!ended) kept[KEY_W-1-8*b -: 8] = key[KEY_W-1-8*b -: 8];
      end
      return kept;
   endfunction

   function automatic int slot_by_name(input logic [KEY_W-1:0] key);
      int hit;
      hit = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (hit < 0 && slot_used[i] && !slot_marked[i] && slot_name[i] == key) hit = i;
      return hit;
   endfunction

   function automatic int slot_by_sector(input logic [SECTOR_W-1:0] sec,
                                         input logic with_marked);
      int hit;
      hit = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (hit < 0 && slot_used[i] && (with_marked || !slot_marked[i]) &&
             slot_sector[i] == sec) hit = i;
      return hit;
   endfunction

   // Applies one request to the shadow directory and returns the response it owes.
   function automatic dir_reply_type apply_request(input logic [FUNC_W-1:0] fn,
                                                   input logic [KEY_W-1:0] raw_key,
                                                   input logic [SECTOR_W-1:0] sec);
      dir_reply_type r;
      logic [KEY_W-1:0] key;
      int slot;
      key      = canonical_name(raw_key);
      slot     = -1;
      r        = '0;
      r.func   = fn;
      r.status = ST_NOT_FOUND;
      case (fn)
         FN_FIND: begin
            slot = slot_by_name(key);
            if (slot >= 0) r.status = ST_OK;
         end
         FN_ADD: begin
            slot = slot_by_name(key);
            if (slot >= 0) begin
               r.status = ST_DUPLICATE;
            end else begin
               r.status = ST_FULL;
               for (int i = 0; i < TABLE_ENTRIES; i++) begin
                  if (slot < 0 && !slot_used[i]) begin
                     slot           = i;
                     slot_used[i]   = 1'b1;
                     slot_marked[i] = 1'b0;
                     slot_name[i]   = key;
                     slot_sector[i] = sec;
                     r.status       = ST_OK;
                  end
               end
            end
         end
         FN_REMOVE: begin
            slot = slot_by_name(key);
            if (slot >= 0) begin
               slot_used[slot] = 1'b0;
               r.status        = ST_OK;
            end
         end
         FN_MARK: begin
            slot = slot_by_sector(sec, 1'b0);
            if (slot >= 0) begin
               slot_marked[slot] = 1'b1;
               r.status          = ST_OK;
            end
         end
         FN_QUERY: begin
            slot = slot_by_sector(sec, 1'b1);
            if (slot >= 0) begin
               r.marked = slot_marked[slot];
               r.status = ST_OK;
            end
         end
         FN_REMOVE_MARKED: begin
            slot = slot_by_sector(sec, 1'b1);
            if (slot >= 0) begin
               if (slot_marked[slot]) begin
                  slot_used[slot] = 1'b0;
                  r.status        = ST_OK;
               end else begin
                  r.status = ST_NOT_MARKED;
               end
            end
         end
         default: ;
      endcase
      if (slot >= 0) begin
         r.sector = slot_sector[slot];
         r.slot   = slot[SLOT_W-1:0];
      end
      return r;
   endfunction

   task automatic log_failure(input string what);
      if (mismatches < 10) $display("%0t ns: %s", $realtime, what);
      mismatches++;
   endtask

   // Inputs are driven and outputs updated with nonblocking assignments, so everything
   // read here holds the values that were present just before the edge.
   always @(posedge clock) begin
      dir_reply_type due;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            slot_used[i]   = 1'b0;
            slot_marked[i] = 1'b0;
         end
         replies_due.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (replies_due.size() == 0) begin
               log_failure($sformatf("response with none outstanding: status %0d sector %h",
                                     rsp_status, rsp_sector_out));
            end else begin
               due = replies_due.pop_front();
               checked_total++;
               if (due.status == ST_FULL) full_total++;
               if (rsp_status !== due.status || rsp_sector_out !== due.sector ||
                   rsp_slot_index !== due.slot || rsp_is_marked !== due.marked)
                  log_failure($sformatf({"func %0d: expected status %0d sector %h slot %0d ",
                                         "mark %b, got status %0d sector %h slot %0d mark %b"},
                                        due.func, due.status, due.sector, due.slot,
                                        due.marked, rsp_status, rsp_sector_out,
                                        rsp_slot_index, rsp_is_marked));
            end
         end
         if (start && !busy)
            replies_due.push_back(apply_request(req_func, req_name_key, req_sector_in));
      end
      error_count     <= mismatches;
      pending_count   <= replies_due.size();
      replies_checked <= checked_total;
      full_replies    <= full_total;
   end

endmodule

FILE: sim/name_directory_table_tb.sv
`timescale 1ns / 1ps

module name_directory_table_tb;
   import ndt_pkg::*;

   // The function field has room for two codes that the block does not define. They
   // must come back as not found and leave the directory alone.
   localparam logic [FUNC_W-1:0] FN_SPARE_LOW  = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_HIGH = 3'd7;

   localparam int RANDOM_REQUESTS = 1880;
   localparam int EPISODE_LEN     = 120;   // requests per traffic mix
   localparam int NAME_POOL       = 96;    // more names than slots, so the table can fill
   localparam int SECTOR_POOL     = 20;    // few sectors, so mark and query often hit
   localparam int MAX_GAP         = 70;    // an idle stretch can cover a whole scan
   // The slowest correct run is about 1900 requests, each a full scan plus a gap of up
   // to MAX_GAP; CYCLE_LIMIT stays well above that and leaves plenty of margin.
   localparam int CYCLE_LIMIT     = 1000000;

   // Traffic mixes for the random part: grow fills the directory until it reports
   // full, churn keeps it around half full, shrink empties it through both the
   // remove by name and the mark then remove marked paths.
   typedef enum int {
      MIX_GROW,
      MIX_CHURN,
      MIX_SHRINK
   } traffic_mix_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                start         = 1'b0;
   logic [FUNC_W-1:0]   req_func      = '0;
   logic [KEY_W-1:0]    req_name_key  = '0;
   logic [SECTOR_W-1:0] req_sector_in = '0;
   logic                busy;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [SECTOR_W-1:0] rsp_sector_out;
   logic [SLOT_W-1:0]   rsp_slot_index;
   logic                rsp_is_marked;

   int check_errors;
   int check_pending;
   int replies_checked;
   int full_replies;
   int cycle_count = 0;
   int op_count[8];

   logic [KEY_W-1:0]    name_pool   [NAME_POOL];
   int                  name_len    [NAME_POOL];
   logic [SECTOR_W-1:0] sector_pool [SECTOR_POOL];

   name_directory_table dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_name_key   (req_name_key),
      .req_sector_in  (req_sector_in),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_sector_out (rsp_sector_out),
      .rsp_slot_index (rsp_slot_index),
      .rsp_is_marked  (rsp_is_marked)
   );

   ndt_reply_checker reply_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_name_key    (req_name_key),
      .req_sector_in   (req_sector_in),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_sector_out  (rsp_sector_out),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_is_marked   (rsp_is_marked),
      .error_count     (check_errors),
      .pending_count   (check_pending),
      .replies_checked (replies_checked),
      .full_replies    (full_replies)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
                  cycle_count, check_pending);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Presents one request and holds it until the block takes it. With a chance of
   // idle_pct percent, start then drops for a random stretch; otherwise the next
   // request follows with start kept high. The busy value read right after the edge
   // is the one the block saw at that edge.
   task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                               input logic [SECTOR_W-1:0] sec, input int idle_pct);
      start         <= 1'b1;
      req_func      <= fn;
      req_name_key  <= key;
      req_sector_in <= sec;
      op_count[fn]++;
      do @(posedge clock); while (busy !== 1'b0);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(MAX_GAP, 1)) @(posedge clock);
      end
   endtask

   // A pool name, sometimes with junk bytes after its zero terminator. The junk must
   // not change which entry the name refers to.
   function automatic logic [KEY_W-1:0] pick_name();
      int idx;
      logic [KEY_W-1:0] junk_mask;
      idx = $urandom_range(NAME_POOL - 1);
      junk_mask = (name_len[idx] <= 6) ? ((64'd1 << (8 * (7 - name_len[idx]))) - 64'd1)
                                       : 64'd0;
      if ($urandom_range(99) < 30)
         return name_pool[idx] | ({$urandom, $urandom} & junk_mask);
      return name_pool[idx];
   endfunction

   function automatic logic [SECTOR_W-1:0] pick_sector();
      if ($urandom_range(99) < 15) return SECTOR_W'($urandom);
      return sector_pool[$urandom_range(SECTOR_POOL - 1)];
   endfunction

   function automatic logic [FUNC_W-1:0] pick_operation(input traffic_mix_type mix);
      int roll;
      int add_pct;
      int remove_pct;
      logic [FUNC_W-1:0] fn;
      roll = $urandom_range(99);
      case (mix)
         MIX_GROW: begin
            add_pct    = 60;
            remove_pct = 8;
         end
         MIX_CHURN: begin
            add_pct    = 28;
            remove_pct = 22;
         end
         default: begin
            add_pct    = 10;
            remove_pct = 35;
         end
      endcase
      // The rest goes a quarter each to find and mark, a fifth to query and the remaining
      // 30 percent to remove marked; mark takes five points from query while emptying.
      if (roll < add_pct) fn = FN_ADD;
      else if (roll < add_pct + remove_pct) fn = FN_REMOVE;
      else begin
         roll = $urandom_range(99);
         if (roll < 25) fn = FN_FIND;
         else if (roll < 50 + (mix == MIX_SHRINK ? 5 : 0)) fn = FN_MARK;
         else if (roll < 70) fn = FN_QUERY;
         else fn = FN_REMOVE_MARKED;
      end
      return fn;
   endfunction

   initial begin
      traffic_mix_type mix;
      int idle_pct;
      logic [FUNC_W-1:0] fn;

      // Names of one to eight bytes, each byte nonzero and drawn from the full range.
      for (int i = 0; i < NAME_POOL; i++) begin
         name_len[i]  = $urandom_range(8, 1);
         name_pool[i] = '0;
         for (int b = 0; b < name_len[i]; b++)
            name_pool[i][KEY_W-1-8*b -: 8] = 8'($urandom_range(255, 1));
      end
      sector_pool[0] = 16'h0000;
      sector_pool[1] = 16'hFFFF;
      for (int i = 2; i < SECTOR_POOL; i++) sector_pool[i] = SECTOR_W'($urandom);
      foreach (op_count[i]) op_count[i] = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first request waits out the clearing pass after reset.
      // A find on the empty directory misses.
      send_request(FN_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8);
      // Extreme keys and sectors: all ones, and the empty name with sector zero.
      send_request(FN_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 8);
      send_request(FN_ADD, 64'h0000_0000_0000_0000, 16'h0000, 8);
      // A one-byte name with junk after its terminator is stored as the bare byte.
      send_request(FN_ADD, 64'h4100_FFFF_FFFF_FFFF, 16'h1234, 8);
      // The same name written without junk is a duplicate.
      send_request(FN_ADD, 64'h4100_0000_0000_0000, 16'h7777, 8);
      send_request(FN_FIND, 64'h4100_5555_AAAA_0001, 16'h0000, 8);
      send_request(FN_FIND, 64'h0000_0000_0000_0000, 16'hFFFF, 8);
      // Once marked, the entry is invisible to name lookups but not to queries.
      send_request(FN_MARK, 64'h0, 16'h1234, 8);
      send_request(FN_FIND, 64'h4100_0000_0000_0000, 16'h0000, 8);
      send_request(FN_QUERY, 64'h0, 16'h1234, 8);
      send_request(FN_MARK, 64'h0, 16'h1234, 8);
      // With the old entry marked, the same name can be added again.
      send_request(FN_ADD, 64'h4100_0000_0000_0000, 16'hABCD, 8);
      send_request(FN_MARK, 64'h0, 16'hFFFF, 8);
      send_request(FN_REMOVE_MARKED, 64'h0, 16'hFFFF, 8);
      // Removing an entry that is not marked is refused.
      send_request(FN_REMOVE_MARKED, 64'h0, 16'h0000, 8);
      send_request(FN_QUERY, 64'h0, 16'h0000, 8);
      send_request(FN_QUERY, 64'h0, 16'h5555, 8);
      send_request(FN_REMOVE, 64'h0000_0000_0000_0000, 16'h0000, 8);
      send_request(FN_REMOVE, 64'h5A5A_5A5A_5A5A_5A5A, 16'h0000, 8);
      send_request(FN_SPARE_LOW, 64'h4100_0000_0000_0000, 16'hABCD, 8);
      send_request(FN_SPARE_HIGH, 64'h4100_0000_0000_0000, 16'hABCD, 8);
      send_request(FN_REMOVE_MARKED, 64'h0, 16'h1234, 8);
      send_request(FN_REMOVE_MARKED, 64'h0, 16'h9999, 8);
      send_request(FN_MARK, 64'h0, 16'h9999, 8);

      // Random part: well-formed traffic on pooled names and sectors, with some
      // noise of arbitrary codes and keys. Idling is light in the first third,
      // heavy in the second and absent in the last.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         idle_pct = (n < RANDOM_REQUESTS / 3) ? 8 : (n < 2 * RANDOM_REQUESTS / 3) ? 59 : 0;
         mix = traffic_mix_type'((n / EPISODE_LEN) % 3);
         if ($urandom_range(99) < 8) begin
            send_request(FUNC_W'($urandom_range(7)), {$urandom, $urandom},
                         SECTOR_W'($urandom), idle_pct);
         end else begin
            fn = pick_operation(mix);
            send_request(fn, pick_name(), pick_sector(), idle_pct);
         end
      end
      start <= 1'b0;

      // Drain, then give the block a full scan's worth of cycles to show any stray
      // response.
      do @(posedge clock); while (check_pending != 0);
      repeat (DEF_TABLE_ENTRIES + 8) @(posedge clock);

      $display("Sent %0d find, %0d add, %0d remove, %0d mark, %0d query, %0d remove marked",
               op_count[FN_FIND], op_count[FN_ADD], op_count[FN_REMOVE], op_count[FN_MARK],
               op_count[FN_QUERY], op_count[FN_REMOVE_MARKED]);
      $display("and %0d spare-code requests; %0d responses checked, %0d of them table full.",
               op_count[FN_SPARE_LOW] + op_count[FN_SPARE_HIGH], replies_checked,
               full_replies);
      if (check_errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d failures.", check_errors);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
